### src/bdq_pkg.sv
package bdq_pkg;

    // Store geometry
    localparam int DEPTH = 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int DW    = 32;

    // Request action codes
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_SEARCH     = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_POP_TAKE,
        OP_SEARCH_START,
        OP_SEARCH_STEP,
        OP_SET_FULL,
        OP_SET_EMPTY,
        OP_SET_FOUND,
        OP_SET_DONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_empty;
        logic is_full;
        logic match;
        logic scan_end;
    } t_dp_stat;

    // Ring position: (base + offset) modulo DEPTH, both operands below DEPTH
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] offset);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

### src/bdq_dp.sv
module bdq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bdq_pkg::t_dp_cmd              i_cmd,
    input  logic signed [bdq_pkg::DW-1:0] i_value,
    output bdq_pkg::t_dp_stat             o_stat,
    output logic [1:0]                    o_status,
    output logic signed [bdq_pkg::DW-1:0] o_data,
    output logic                          o_found
);

    logic [bdq_pkg::DW-1:0]        r_mem [bdq_pkg::DEPTH];
    logic [bdq_pkg::DW-1:0]        r_rd_data;
    logic signed [bdq_pkg::DW-1:0] r_key;
    logic [bdq_pkg::AW-1:0]        r_front, n_front;
    logic [bdq_pkg::OCC_W-1:0]     r_occ, n_occ;
    logic [bdq_pkg::OCC_W-1:0]     r_cnt, n_cnt;
    logic [1:0]                    r_status, n_status;
    logic signed [bdq_pkg::DW-1:0] r_data, n_data;
    logic                          r_found, n_found;

    logic                          wr_en;
    logic [bdq_pkg::AW-1:0]        wr_addr;
    logic                          rd_en;
    logic [bdq_pkg::AW-1:0]        rd_addr;
    logic [bdq_pkg::AW-1:0]        front_dec;
    logic [bdq_pkg::OCC_W-1:0]     occ_dec;

    assign front_dec = (r_front == '0) ? bdq_pkg::AW'(bdq_pkg::DEPTH - 1)
                                       : r_front - bdq_pkg::AW'(1);
    assign occ_dec   = r_occ - bdq_pkg::OCC_W'(1);

    // Decode the command into store accesses and next register values
    always_comb begin
        n_front  = r_front;
        n_occ    = r_occ;
        n_cnt    = r_cnt;
        n_status = r_status;
        n_data   = r_data;
        n_found  = r_found;
        wr_en    = 1'b0;
        wr_addr  = front_dec;
        rd_en    = 1'b0;
        rd_addr  = r_front;
        unique case (i_cmd.op)
            bdq_pkg::OP_PUSH_FRONT: begin
                wr_en    = 1'b1;
                wr_addr  = front_dec;
                n_front  = front_dec;
                n_occ    = r_occ + bdq_pkg::OCC_W'(1);
                n_status = bdq_pkg::ST_DONE;
                n_data   = '0;
                n_found  = 1'b0;
            end
            bdq_pkg::OP_PUSH_BACK: begin
                wr_en    = 1'b1;
                wr_addr  = bdq_pkg::ring_add(r_front, r_occ[bdq_pkg::AW-1:0]);
                n_occ    = r_occ + bdq_pkg::OCC_W'(1);
                n_status = bdq_pkg::ST_DONE;
                n_data   = '0;
                n_found  = 1'b0;
            end
            bdq_pkg::OP_POP_FRONT: begin
                rd_en    = 1'b1;
                rd_addr  = r_front;
                n_front  = bdq_pkg::ring_add(r_front, bdq_pkg::AW'(1));
                n_occ    = occ_dec;
                n_status = bdq_pkg::ST_DONE;
                n_found  = 1'b0;
            end
            bdq_pkg::OP_POP_BACK: begin
                rd_en    = 1'b1;
                rd_addr  = bdq_pkg::ring_add(r_front, occ_dec[bdq_pkg::AW-1:0]);
                n_occ    = occ_dec;
                n_status = bdq_pkg::ST_DONE;
                n_found  = 1'b0;
            end
            bdq_pkg::OP_POP_TAKE: begin
                n_data = r_rd_data;
            end
            bdq_pkg::OP_SEARCH_START: begin
                rd_en   = 1'b1;
                rd_addr = r_front;
                n_cnt   = bdq_pkg::OCC_W'(1);
            end
            bdq_pkg::OP_SEARCH_STEP: begin
                rd_en   = 1'b1;
                rd_addr = bdq_pkg::ring_add(r_front, r_cnt[bdq_pkg::AW-1:0]);
                n_cnt   = r_cnt + bdq_pkg::OCC_W'(1);
            end
            bdq_pkg::OP_SET_FULL: begin
                n_status = bdq_pkg::ST_FULL;
                n_data   = '0;
                n_found  = 1'b0;
            end
            bdq_pkg::OP_SET_EMPTY: begin
                n_status = bdq_pkg::ST_EMPTY;
                n_data   = '0;
                n_found  = 1'b0;
            end
            bdq_pkg::OP_SET_FOUND: begin
                n_status = bdq_pkg::ST_DONE;
                n_data   = '0;
                n_found  = 1'b1;
            end
            bdq_pkg::OP_SET_DONE: begin
                n_status = bdq_pkg::ST_DONE;
                n_data   = '0;
                n_found  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Ring store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Hold the search key for the whole scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bdq_pkg::OP_SEARCH_START) begin
            r_key <= i_value;
        end
    end

    // Queue pointers and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_occ   <= '0;
            r_cnt   <= '0;
        end else begin
            r_front <= n_front;
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_found  <= n_found;
    end

    assign o_stat.is_empty = (r_occ == '0);
    assign o_stat.is_full  = (r_occ == bdq_pkg::OCC_W'(bdq_pkg::DEPTH));
    assign o_stat.match    = ($signed(r_rd_data) == r_key);
    assign o_stat.scan_end = (r_cnt == r_occ);

    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_found  = r_found;

endmodule

### src/bdq_ctrl.sv
module bdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_action,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  bdq_pkg::t_dp_stat i_stat,
    output bdq_pkg::t_dp_cmd  o_cmd
);

    bdq_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd.op    = bdq_pkg::OP_NONE;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            bdq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = bdq_pkg::S_OUT;
                    unique case (i_action)
                        bdq_pkg::ACT_PUSH_FRONT: begin
                            o_cmd.op = i_stat.is_full ? bdq_pkg::OP_SET_FULL
                                                      : bdq_pkg::OP_PUSH_FRONT;
                        end
                        bdq_pkg::ACT_PUSH_BACK: begin
                            o_cmd.op = i_stat.is_full ? bdq_pkg::OP_SET_FULL
                                                      : bdq_pkg::OP_PUSH_BACK;
                        end
                        bdq_pkg::ACT_POP_FRONT: begin
                            if (i_stat.is_empty) begin
                                o_cmd.op = bdq_pkg::OP_SET_EMPTY;
                            end else begin
                                o_cmd.op = bdq_pkg::OP_POP_FRONT;
                                n_state  = bdq_pkg::S_POP;
                            end
                        end
                        bdq_pkg::ACT_POP_BACK: begin
                            if (i_stat.is_empty) begin
                                o_cmd.op = bdq_pkg::OP_SET_EMPTY;
                            end else begin
                                o_cmd.op = bdq_pkg::OP_POP_BACK;
                                n_state  = bdq_pkg::S_POP;
                            end
                        end
                        bdq_pkg::ACT_SEARCH: begin
                            if (i_stat.is_empty) begin
                                o_cmd.op = bdq_pkg::OP_SET_DONE;
                            end else begin
                                o_cmd.op = bdq_pkg::OP_SEARCH_START;
                                n_state  = bdq_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            o_cmd.op = bdq_pkg::OP_SET_DONE;
                        end
                    endcase
                end
            end
            bdq_pkg::S_POP: begin
                // take the read data into the result register
                o_cmd.op = bdq_pkg::OP_POP_TAKE;
                n_state  = bdq_pkg::S_OUT;
            end
            bdq_pkg::S_SCAN: begin
                // compare the entry read last cycle; on no match and no scan end, read the next one
                if (i_stat.match) begin
                    o_cmd.op = bdq_pkg::OP_SET_FOUND;
                    n_state  = bdq_pkg::S_OUT;
                end else if (i_stat.scan_end) begin
                    o_cmd.op = bdq_pkg::OP_SET_DONE;
                    n_state  = bdq_pkg::S_OUT;
                end else begin
                    o_cmd.op = bdq_pkg::OP_SEARCH_STEP;
                end
            end
            bdq_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = bdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bdq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### src/bounded_deque_with_search.sv
// One request at a time, set by the sequencer: a new one is taken only in idle,
//   after the result beat leaves (held while stalled). Push, refused push/pop
//   and empty search go straight to the result beat; pop reads the store
//   (registered read), then takes the data; search reads and compares k entries.
// Reset: synchronous, active low; empties the queue (front and count to zero).
//   Store contents are not cleared and need no clearing pass.
module bounded_deque_with_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_action,
    input  logic signed [bdq_pkg::DW-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic signed [bdq_pkg::DW-1:0] o_data,
    output logic                          o_found
);

    bdq_pkg::t_dp_cmd  dp_cmd;
    bdq_pkg::t_dp_stat dp_stat;

    // Sequencer
    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Ring store, pointers and result register
    bdq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_value  (i_value),
        .o_stat   (dp_stat),
        .o_status (o_status),
        .o_data   (o_data),
        .o_found  (o_found)
    );

endmodule
